// ===== rtl/core/ipari_pkg.sv =====
// Shared types, operation and status codes for the IP address range iterator.
// No dependencies; imported by every module of the block.
package ipari_pkg;

   // Operation codes carried by an input beat
   localparam logic [1:0] OP_LOAD_PREFIX = 2'd0;
   localparam logic [1:0] OP_LOAD_RANGE  = 2'd1;
   localparam logic [1:0] OP_NEXT        = 2'd2;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EXPIRED  = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   // Address family widths and the longest legal prefix
   localparam int V4_BITS    = 32;
   localparam int V6_BITS    = 128;
   localparam int MAX_PREFIX = 128;

   typedef struct packed {
      logic [1:0]  operation;
      logic        is_ipv6;
      logic [63:0] first_hi;
      logic [63:0] first_lo;
      logic [63:0] last_hi;
      logic [63:0] last_lo;
      logic [7:0]  prefix_len;
      logic [31:0] first_scope;
      logic [31:0] last_scope;
   } req_type;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        addr_valid;
      logic [1:0]  status;
   } rsp_type;

   // Iterator state: current and end address (IPv4 zero-extended), family, done flag
   typedef struct packed {
      logic [V6_BITS-1:0] cur;
      logic [V6_BITS-1:0] last;
      logic               v6;
      logic               done;
   } state_type;

endpackage

// ===== rtl/core/ipari_step.sv =====
// Next-state and result logic for one beat of the address range iterator.
// Purely combinational; depends on ipari_pkg.
module ipari_step import ipari_pkg::*; (
   input  state_type cur_state,
   input  req_type   req,
   output state_type nxt_state,
   output rsp_type   rsp,
   output logic      has_rsp
);

   logic [V6_BITS-1:0] first_a;
   logic [V6_BITS-1:0] last_a;
   logic [V6_BITS-1:0] host_mask;
   logic [V6_BITS-1:0] cur_up;
   logic [V6_BITS-1:0] cur_dn;
   logic [7:0]         host_cnt;
   logic               cur_lt;

   // Operand shaping: IPv4 keeps only the low 32 bits
   always_comb begin
      if (req.is_ipv6) begin
         first_a = {req.first_hi, req.first_lo};
         last_a  = {req.last_hi, req.last_lo};
      end else begin
         first_a = {{(V6_BITS-V4_BITS){1'b0}}, req.first_lo[V4_BITS-1:0]};
         last_a  = {{(V6_BITS-V4_BITS){1'b0}}, req.last_lo[V4_BITS-1:0]};
      end
   end

   // Host-bit count and mask; IPv4 prefixes past /32 collapse to one address
   always_comb begin
      if (req.is_ipv6) begin
         host_cnt = 8'(V6_BITS) - req.prefix_len;
      end else if (req.prefix_len > 8'(V4_BITS)) begin
         host_cnt = 8'd0;
      end else begin
         host_cnt = 8'(V4_BITS) - req.prefix_len;
      end
      host_mask = ({{(V6_BITS-1){1'b0}}, 1'b1} << host_cnt) - {{(V6_BITS-1){1'b0}}, 1'b1};
   end

   // Step by one, wrapping within the family width
   always_comb begin
      if (cur_state.v6) begin
         cur_up = cur_state.cur + {{(V6_BITS-1){1'b0}}, 1'b1};
         cur_dn = cur_state.cur - {{(V6_BITS-1){1'b0}}, 1'b1};
      end else begin
         cur_up = {{(V6_BITS-V4_BITS){1'b0}},
                   cur_state.cur[V4_BITS-1:0] + {{(V4_BITS-1){1'b0}}, 1'b1}};
         cur_dn = {{(V6_BITS-V4_BITS){1'b0}},
                   cur_state.cur[V4_BITS-1:0] - {{(V4_BITS-1){1'b0}}, 1'b1}};
      end
      cur_lt = cur_state.cur < cur_state.last;
   end

   // Operation decode
   always_comb begin
      nxt_state = cur_state;
      rsp       = '0;
      has_rsp   = 1'b1;
      case (req.operation)
         OP_LOAD_PREFIX: begin
            if (req.prefix_len > 8'(MAX_PREFIX)) begin
               nxt_state.done = 1'b1;
               rsp.status     = ST_REJECTED;
            end else begin
               nxt_state.cur  = first_a & ~host_mask;
               nxt_state.last = first_a | host_mask;
               nxt_state.v6   = req.is_ipv6;
               nxt_state.done = 1'b0;
               rsp.status     = ST_OK;
            end
         end
         OP_LOAD_RANGE: begin
            if (req.is_ipv6 && (req.first_scope != req.last_scope)) begin
               nxt_state.done = 1'b1;
               rsp.status     = ST_REJECTED;
            end else begin
               nxt_state.cur  = first_a;
               nxt_state.last = last_a;
               nxt_state.v6   = req.is_ipv6;
               nxt_state.done = 1'b0;
               rsp.status     = ST_OK;
            end
         end
         OP_NEXT: begin
            if (cur_state.done) begin
               rsp.status = ST_EXPIRED;
            end else begin
               rsp.addr_hi    = cur_state.cur[V6_BITS-1:64];
               rsp.addr_lo    = cur_state.cur[63:0];
               rsp.addr_valid = 1'b1;
               rsp.status     = ST_OK;
               if (cur_state.cur == cur_state.last) begin
                  nxt_state.done = 1'b1;
               end else if (cur_lt) begin
                  nxt_state.cur = cur_up;
               end else begin
                  nxt_state.cur = cur_dn;
               end
            end
         end
         default: begin
            // unused code: no result, state untouched
            has_rsp = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/ipari_skid.sv =====
// Two-entry result buffer: output register plus one skid stage.
// Depends on ipari_pkg for the result beat type.
module ipari_skid import ipari_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop = out_vld_ff && !rsp_stall;

   // Refill the output register from the skid stage first to keep order
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (!out_vld_ff || pop) begin
         if (skid_vld_ff) begin
            out_vld_in   = 1'b1;
            out_data_in  = skid_data_ff;
            skid_vld_in  = push;
            skid_data_in = push_data;
         end else begin
            out_vld_in  = push;
            out_data_in = push_data;
         end
      end else if (push) begin
         skid_vld_in  = 1'b1;
         skid_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/core/ip_address_range_iterator.sv =====
// Top level of the IPv4/IPv6 address range iterator.
// Uses ipari_pkg, ipari_step and ipari_skid.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_type  (load prefix, load range, next)
//   rsp      out        rsp_valid/stall    rsp_type  (address, valid flag, status)
//
// One beat per clock while req_stall is low: the 128-bit compare and step settle in the cycle a beat
// is taken, updating the state register and writing the result buffer.
// A result is registered in the output register, or in the skid stage while rsp_stall holds it.
// Synchronous reset leaves nothing loaded: a next request reports expired.
// req_stall rises only while both result entries are held by rsp_stall.
module ip_address_range_iterator import ipari_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   state_type step_state;
   rsp_type   step_rsp;
   logic      step_has_rsp;
   logic      accept;

   assign accept = req_valid && !req_stall;

   ipari_step u_step (
      .cur_state (state_ff),
      .req       (req_data),
      .nxt_state (step_state),
      .rsp       (step_rsp),
      .has_rsp   (step_has_rsp)
   );

   // Iterator state
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         // addresses and family cleared, done flag (lowest bit) set
         state_ff <= {{(2*V6_BITS+1){1'b0}}, 1'b1};
      end else begin
         state_ff <= state_in;
      end
   end

   ipari_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step_has_rsp),
      .push_data (step_rsp),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry held with empty output register");

   a_v4_upper_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.v6 |-> (state_ff.cur[V6_BITS-1:V4_BITS] == '0 &&
                        state_ff.last[V6_BITS-1:V4_BITS] == '0))
      else $error("IPv4 state carries upper address bits");

   a_unused_no_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_UNUSED && !rsp_valid) |=> !rsp_valid)
      else $error("unused operation produced a result beat");

endmodule

// ===== sim/tb_ip_address_range_iterator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ip_address_range_iterator: directed and random prefix
// loads, range loads and next requests, each result beat checked against a predictor.
// Depends on ipari_pkg and the block's RTL; reads no files.
module tb_ip_address_range_iterator import ipari_pkg::*; ();

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ip_address_range_iterator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predicted iterator state, IPv4 held zero-extended
   logic [127:0] iter_cur  = '0;
   logic [127:0] iter_end  = '0;
   logic         iter_v6   = 1'b0;
   logic         iter_done = 1'b1;

   rsp_type     expected_addresses[$];
   int          error_count = 0;
   bit          send_idle   = 1'b0;
   bit          rsp_idle    = 1'b0;
   int unsigned stall_left  = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Generous time limit that ends a hung run as failed
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int draw_wait(bit enabled);
      return enabled ? $urandom_range(16, 0) : 0;
   endfunction

   function automatic logic [127:0] rand128();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic req_type make_req(logic [1:0] op, logic v6, logic [127:0] first,
                                        logic [127:0] last, logic [7:0] plen,
                                        logic [31:0] fscope, logic [31:0] lscope);
      req_type r;
      r.operation             = op;
      r.is_ipv6               = v6;
      {r.first_hi, r.first_lo} = first;
      {r.last_hi, r.last_lo}   = last;
      r.prefix_len            = plen;
      r.first_scope           = fscope;
      r.last_scope            = lscope;
      return r;
   endfunction

   // Work out the result of one accepted beat and advance the predicted state
   function automatic void predict_address_beat(req_type r);
      rsp_type      res;
      logic [127:0] base;
      logic [127:0] mask;
      logic [31:0]  mask4;
      int           host;
      res = '0;
      case (r.operation)
         OP_LOAD_PREFIX: begin
            if (r.prefix_len > MAX_PREFIX) begin
               iter_done  = 1'b1;
               res.status = ST_REJECTED;
            end else begin
               if (r.is_ipv6) begin
                  host = V6_BITS - r.prefix_len;
                  mask = ~({128{1'b1}} << host);
                  base = {r.first_hi, r.first_lo};
               end else begin
                  // prefixes longer than 32 collapse to a single address
                  host  = (r.prefix_len > V4_BITS) ? 0 : V4_BITS - r.prefix_len;
                  mask4 = ~(32'hffff_ffff << host);
                  mask  = {96'd0, mask4};
                  base  = {96'd0, r.first_lo[31:0]};
               end
               iter_cur   = base & ~mask;
               iter_end   = base | mask;
               iter_v6    = r.is_ipv6;
               iter_done  = 1'b0;
               res.status = ST_OK;
            end
            expected_addresses.push_back(res);
         end
         OP_LOAD_RANGE: begin
            if (r.is_ipv6 && r.first_scope != r.last_scope) begin
               iter_done  = 1'b1;
               res.status = ST_REJECTED;
            end else begin
               if (r.is_ipv6) begin
                  iter_cur = {r.first_hi, r.first_lo};
                  iter_end = {r.last_hi, r.last_lo};
               end else begin
                  iter_cur = {96'd0, r.first_lo[31:0]};
                  iter_end = {96'd0, r.last_lo[31:0]};
               end
               iter_v6    = r.is_ipv6;
               iter_done  = 1'b0;
               res.status = ST_OK;
            end
            expected_addresses.push_back(res);
         end
         OP_NEXT: begin
            if (iter_done) begin
               res.status = ST_EXPIRED;
            end else begin
               {res.addr_hi, res.addr_lo} = iter_cur;
               res.addr_valid = 1'b1;
               res.status     = ST_OK;
               if (iter_cur == iter_end) begin
                  iter_done = 1'b1;
               end else begin
                  // step one toward the end, wrapping at the family width
                  iter_cur = (iter_cur < iter_end) ? iter_cur + 128'd1 : iter_cur - 128'd1;
                  if (!iter_v6) iter_cur = {96'd0, iter_cur[31:0]};
               end
            end
            expected_addresses.push_back(res);
         end
         default: ;  // unused code: no result, state kept
      endcase
   endfunction

   // Compare one result beat with the oldest prediction
   function automatic void check_address_beat(rsp_type got);
      rsp_type want;
      if (expected_addresses.size() == 0) begin
         $display("%0t: result beat with none outstanding: expected none, actual %h",
                  $time, got);
         error_count++;
         return;
      end
      want = expected_addresses.pop_front();
      if (got.addr_hi !== want.addr_hi) begin
         $display("%0t: addr_hi expected %h actual %h", $time, want.addr_hi, got.addr_hi);
         error_count++;
      end
      if (got.addr_lo !== want.addr_lo) begin
         $display("%0t: addr_lo expected %h actual %h", $time, want.addr_lo, got.addr_lo);
         error_count++;
      end
      if (got.addr_valid !== want.addr_valid) begin
         $display("%0t: addr_valid expected %b actual %b", $time, want.addr_valid,
                  got.addr_valid);
         error_count++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         error_count++;
      end
   endfunction

   // Result side: take beats, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_address_beat(rsp_data);
         stall_left = draw_wait(rsp_idle);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Drive one request beat after a drawn gap; hold it until taken
   task automatic send_beat(req_type item);
      int idle;
      idle = draw_wait(send_idle);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_address_beat(item);
   endtask

   // Next requests carry random bits in fields the block ignores
   task automatic send_nexts(int count);
      repeat (count) begin
         send_beat(make_req(OP_NEXT, 1'($urandom_range(1, 0)), rand128(), rand128(),
                            8'($urandom_range(255, 0)), $urandom, $urandom));
      end
   endtask

   task automatic test_nothing_loaded();
      send_nexts(1);
      send_beat(make_req(OP_UNUSED, 1'b1, rand128(), rand128(), 8'd0, $urandom, $urandom));
      send_nexts(1);
   endtask

   task automatic test_prefix_loads();
      // IPv4 /30 with junk in the upper input bits, walked past its end
      send_beat(make_req(OP_LOAD_PREFIX, 1'b0,
                         {64'hffff_ffff_ffff_ffff, 64'hffff_ffff_c0a8_0105},
                         rand128(), 8'd30, $urandom, $urandom));
      send_nexts(5);
      // IPv4 prefix past 32 acts as a host route
      send_beat(make_req(OP_LOAD_PREFIX, 1'b0, rand128(), rand128(), 8'd33,
                         32'd0, 32'd1));
      send_nexts(1);
      // whole address space of each family, then an IPv6 /128
      send_beat(make_req(OP_LOAD_PREFIX, 1'b0, rand128(), rand128(), 8'd0,
                         32'd0, 32'd0));
      send_nexts(1);
      send_beat(make_req(OP_LOAD_PREFIX, 1'b1, {128{1'b1}}, '0, 8'd0, 32'd0, 32'd0));
      send_nexts(1);
      send_beat(make_req(OP_LOAD_PREFIX, 1'b1, {128{1'b1}}, '0, 8'd128, 32'd0, 32'd0));
      send_nexts(2);
      // prefixes above 128 are refused
      send_beat(make_req(OP_LOAD_PREFIX, 1'b1, rand128(), rand128(), 8'd129,
                         32'd0, 32'd0));
      send_beat(make_req(OP_LOAD_PREFIX, 1'b0, rand128(), rand128(), 8'd255,
                         32'd0, 32'd0));
      send_nexts(1);
   endtask

   task automatic test_range_loads();
      // IPv6 upward across the 64-bit word boundary
      send_beat(make_req(OP_LOAD_RANGE, 1'b1, {64'h0, 64'hffff_ffff_ffff_fffe},
                         {64'h1, 64'h1}, 8'hff, 32'hffff_ffff, 32'hffff_ffff));
      send_nexts(3);
      // IPv6 downward with a borrow into the upper word
      send_beat(make_req(OP_LOAD_RANGE, 1'b1, {64'h5, 64'h1},
                         {64'h4, 64'hffff_ffff_ffff_ffff}, 8'd0, 32'd7, 32'd7));
      send_nexts(4);
      // IPv6 scope ids differ: refused
      send_beat(make_req(OP_LOAD_RANGE, 1'b1, rand128(), rand128(), 8'd0, 32'd0, 32'd1));
      send_nexts(1);
      // IPv4 single address, scopes ignored, upper bits ignored
      send_beat(make_req(OP_LOAD_RANGE, 1'b0, {{96{1'b1}}, 32'h0a00_0001},
                         {{96{1'b1}}, 32'h0a00_0001}, 8'd0, 32'd3, 32'd9));
      send_nexts(2);
      // IPv4 downward
      send_beat(make_req(OP_LOAD_RANGE, 1'b0, 128'd2, 128'd0, 8'd0, 32'd0, 32'd0));
      send_nexts(2);
   endtask

   // Mostly loads of short ranges walked to or near their end, some noise
   task automatic test_random_sequences(int target);
      int           sent;
      int           pick;
      int           span;
      int           walk;
      logic         v6;
      logic [7:0]   plen;
      logic [31:0]  fscope;
      logic [127:0] first;
      logic [127:0] last;
      req_type      r;
      sent = 0;
      while (sent < target) begin
         send_idle = ($urandom_range(3, 0) != 0);
         rsp_idle  = ($urandom_range(3, 0) != 0);
         pick      = $urandom_range(9, 0);
         v6        = 1'($urandom_range(1, 0));
         first     = rand128();
         if (pick <= 3) begin
            if ($urandom_range(7, 0) == 0) plen = 8'($urandom_range(255, 0));
            else plen = v6 ? 8'($urandom_range(128, 121)) : 8'($urandom_range(32, 26));
            send_beat(make_req(OP_LOAD_PREFIX, v6, first, rand128(), plen,
                               $urandom, $urandom));
            walk = $urandom_range(70, 1);
            send_nexts(walk);
            sent += 1 + walk;
         end else if (pick <= 7) begin
            span   = $urandom_range(40, 0);
            last   = $urandom_range(1, 0) ? first + 128'(span) : first - 128'(span);
            fscope = $urandom;
            send_beat(make_req(OP_LOAD_RANGE, v6, first, last, 8'($urandom_range(255, 0)),
                               fscope, ($urandom_range(7, 0) == 0) ? $urandom : fscope));
            walk = $urandom_range(span + 3, 1);
            send_nexts(walk);
            sent += 1 + walk;
         end else if (pick == 8) begin
            walk = $urandom_range(5, 1);
            send_nexts(walk);
            sent += walk;
         end else begin
            r = make_req(2'($urandom_range(3, 0)), v6, first, rand128(),
                         8'($urandom_range(255, 0)), $urandom, $urandom);
            send_beat(r);
            if (r.operation != OP_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
      test_nothing_loaded();
      test_prefix_loads();
      test_range_loads();
      test_random_sequences(700);
      req_valid <= 1'b0;
      // drain, then keep watching for any stray beat
      while (expected_addresses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
